/* rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants for the hsv to rgb converter: default fraction width and
// the hue sector codes.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int DEF_FRAC_BITS = 16;

	localparam int SECTOR_W = 3;
	typedef logic [SECTOR_W-1:0] sector_t;

	localparam sector_t SEC_RED_YELLOW    = 3'd0;
	localparam sector_t SEC_YELLOW_GREEN  = 3'd1;
	localparam sector_t SEC_GREEN_CYAN    = 3'd2;
	localparam sector_t SEC_CYAN_BLUE     = 3'd3;
	localparam sector_t SEC_BLUE_MAGENTA  = 3'd4;
	localparam sector_t SEC_MAGENTA_RED   = 3'd5;

endpackage

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Four-stage pipelined fixed point hsv to rgb conversion, one color per item.
//
//   channel | valid     | stall      | payload
//   --------+-----------+------------+---------------------------------
//   in      | in_valid  | in_stall   | hue, saturation, brightness
//   out     | out_valid | out_stall  | red, green, blue
//
// one item per cycle sustained while out_stall is low; out_valid is the stage 4 valid bit
// the two multiplies (v*s, then c*weight) sit in stages of their own and set the depth
// stage 1 clamps and forms hue*6, stage 4 orders the channels and adds the offset
// reset clears the valid bits only
// the whole pipeline holds while a result waits under out_stall; in_stall follows
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = hsvrgb_pkg::DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FRAC_BITS-1:0] hue,
	input  logic [FRAC_BITS:0]   saturation,
	input  logic [FRAC_BITS:0]   brightness,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FRAC_BITS:0]   red,
	output logic [FRAC_BITS:0]   green,
	output logic [FRAC_BITS:0]   blue
);

	localparam int CW = FRAC_BITS + 1;
	localparam int HW = FRAC_BITS + hsvrgb_pkg::SECTOR_W;
	localparam int PW = 2 * CW;
	localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic en;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic [CW-1:0]         sat_s1, val_s1;
	hsvrgb_pkg::sector_t   sector_s1, sector_s2, sector_s3;
	logic [FRAC_BITS-1:0]  frac_s1;
	logic [CW-1:0]         chroma_s2, val_s2, weight_s2;
	logic [CW-1:0]         chroma_s3, second_s3, offset_s3;
	logic [CW-1:0]         red_s4, green_s4, blue_s4;

	logic [CW-1:0] sat_clamp, val_clamp;
	logic [HW-1:0] hue6;
	logic [PW-1:0] prod_vs, prod_cw;
	logic [CW-1:0] frac_ext, chroma_c, weight_c;
	logic [CW-1:0] r_c, g_c, b_c;

	assign en       = !valid_s4 || !out_stall;
	assign in_stall = !en;

	// stage 1: clamp and hue times six
	assign sat_clamp = (saturation > ONE) ? ONE : saturation;
	assign val_clamp = (brightness > ONE) ? ONE : brightness;
	assign hue6      = HW'({hue, 2'b00}) + HW'({hue, 1'b0});

	// stage 2: chroma and sector weight
	assign prod_vs  = PW'(sat_s1) * PW'(val_s1);
	assign chroma_c = prod_vs[FRAC_BITS +: CW];
	assign frac_ext = {1'b0, frac_s1};
	assign weight_c = sector_s1[0] ? (ONE - frac_ext) : frac_ext;

	// stage 3: second component and offset
	assign prod_cw = PW'(chroma_s2) * PW'(weight_s2);

	// stage 4: channel order
	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		case (sector_s3)
			hsvrgb_pkg::SEC_RED_YELLOW: begin
				r_c = chroma_s3;
				g_c = second_s3;
			end
			hsvrgb_pkg::SEC_YELLOW_GREEN: begin
				r_c = second_s3;
				g_c = chroma_s3;
			end
			hsvrgb_pkg::SEC_GREEN_CYAN: begin
				g_c = chroma_s3;
				b_c = second_s3;
			end
			hsvrgb_pkg::SEC_CYAN_BLUE: begin
				g_c = second_s3;
				b_c = chroma_s3;
			end
			hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
				r_c = second_s3;
				b_c = chroma_s3;
			end
			default: begin
				r_c = chroma_s3;
				b_c = second_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s1    <= sat_clamp;
			val_s1    <= val_clamp;
			sector_s1 <= hue6[HW-1:FRAC_BITS];
			frac_s1   <= hue6[FRAC_BITS-1:0];

			chroma_s2 <= chroma_c;
			val_s2    <= val_s1;
			weight_s2 <= weight_c;
			sector_s2 <= sector_s1;

			chroma_s3 <= chroma_s2;
			second_s3 <= prod_cw[FRAC_BITS +: CW];
			offset_s3 <= val_s2 - chroma_s2;
			sector_s3 <= sector_s2;

			red_s4   <= r_c + offset_s3;
			green_s4 <= g_c + offset_s3;
			blue_s4  <= b_c + offset_s3;
		end
	end

	assign out_valid = valid_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

endmodule

/* rtl/hsvrgb_checker.sv */
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks for the hsv to rgb converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker #(
	parameter int FRAC_BITS = hsvrgb_pkg::DEF_FRAC_BITS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [FRAC_BITS-1:0] hue,
	input logic [FRAC_BITS:0]   saturation,
	input logic [FRAC_BITS:0]   brightness,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [FRAC_BITS:0]   red,
	input logic [FRAC_BITS:0]   green,
	input logic [FRAC_BITS:0]   blue
);

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("stalled result changed");

	// stalled input item stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("stalled input item changed");

	// no channel above one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red <= ONE && green <= ONE && blue <= ONE)
		else $error("channel above one");

	// empty output never pushes back
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// an accepted item comes out when the pipeline runs on without a stall
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
		else $error("item lost in pipeline");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker #(.FRAC_BITS(FRAC_BITS)) u_hsvrgb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.red        (red),
	.green      (green),
	.blue       (blue)
);

/* tb/tb_hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Self-checking bench for the hsv to rgb converter. A scoreboard computes the
// expected color for every accepted item and checks each result in order.
// Stimulus covers directed corner colors, then random colors under several
// mixes of sender gaps and receiver stalls, plus a long output hold-off.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

	localparam int FB = hsvrgb_pkg::DEF_FRAC_BITS;
	localparam logic [63:0] ONE = 64'd1 << FB;
	localparam logic [63:0] FMASK = ONE - 64'd1;
	localparam int CH_MAX = (1 << (FB + 1)) - 1;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 330;

	typedef struct packed {
		logic [FB:0] red;
		logic [FB:0] green;
		logic [FB:0] blue;
	} rgb_t;

	class color_scoreboard;
		rgb_t expected_q[$];
		int errors;
		int matched;
		int noted;

		function new();
			errors = 0;
			matched = 0;
			noted = 0;
		endfunction

		static function rgb_t convert(logic [FB-1:0] h, logic [FB:0] s, logic [FB:0] v);
			logic [63:0] sc, vc, c, h6, f, x, m, r, g, b;
			hsvrgb_pkg::sector_t sec;
			rgb_t res;
			sc = (64'(s) > ONE) ? ONE : 64'(s);
			vc = (64'(v) > ONE) ? ONE : 64'(v);
			c = (vc * sc) >> FB;
			h6 = 64'(h) * 64'd6;
			sec = hsvrgb_pkg::sector_t'(h6 >> FB);
			f = h6 & FMASK;
			x = sec[0] ? ((c * (ONE - f)) >> FB) : ((c * f) >> FB);
			m = vc - c;
			case (sec)
				hsvrgb_pkg::SEC_RED_YELLOW: begin
					r = c; g = x; b = '0;
				end
				hsvrgb_pkg::SEC_YELLOW_GREEN: begin
					r = x; g = c; b = '0;
				end
				hsvrgb_pkg::SEC_GREEN_CYAN: begin
					r = '0; g = c; b = x;
				end
				hsvrgb_pkg::SEC_CYAN_BLUE: begin
					r = '0; g = x; b = c;
				end
				hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
					r = x; g = '0; b = c;
				end
				default: begin
					r = c; g = '0; b = x;
				end
			endcase
			res.red = (FB+1)'(r + m);
			res.green = (FB+1)'(g + m);
			res.blue = (FB+1)'(b + m);
			return res;
		endfunction

		function void note_input(logic [FB-1:0] h, logic [FB:0] s, logic [FB:0] v);
			expected_q.push_back(convert(h, s, v));
			noted++;
		endfunction

		function void check_result(logic [FB:0] r, logic [FB:0] g, logic [FB:0] b);
			rgb_t exp_c;
			if (expected_q.size() == 0) begin
				$error("result with no item pending: red %0d green %0d blue %0d", r, g, b);
				errors++;
				return;
			end
			exp_c = expected_q.pop_front();
			if (r !== exp_c.red) begin
				$error("red mismatch: expected %0d, actual %0d", exp_c.red, r);
				errors++;
			end
			if (g !== exp_c.green) begin
				$error("green mismatch: expected %0d, actual %0d", exp_c.green, g);
				errors++;
			end
			if (b !== exp_c.blue) begin
				$error("blue mismatch: expected %0d, actual %0d", exp_c.blue, b);
				errors++;
			end
			matched++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FB-1:0] hue = '0;
	logic [FB:0] saturation = '0;
	logic [FB:0] brightness = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FB:0] red;
	logic [FB:0] green;
	logic [FB:0] blue;

	int send_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	color_scoreboard sb = new();

	hsv_to_rgb_converter #(
		.FRAC_BITS(FB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(hue, saturation, brightness);
			if (out_valid && !out_stall)
				sb.check_result(red, green, blue);
		end
	end

	// output side: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_item(logic [FB-1:0] h, logic [FB:0] s, logic [FB:0] v);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
	endtask

	function automatic logic [FB:0] rand_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return (FB+1)'(ONE);
			2: return (FB+1)'($urandom_range(32'(CH_MAX), 32'(ONE) + 32'd1));
			default: return (FB+1)'($urandom_range(32'(ONE), 32'd0));
		endcase
	endfunction

	task automatic send_random(int count);
		repeat (count)
			send_item((FB)'($urandom), rand_channel(), rand_channel());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner colors, sector edges and clamping
		send_item('0, '0, '0);
		send_item('1, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item('0, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd10923, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd21846, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd32768, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd43691, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd54614, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd10922, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd21845, (FB+1)'(ONE), (FB+1)'(ONE));
		send_item(16'd32767, 17'd65535, 17'd65535);
		send_item(16'd43690, 17'd40000, 17'd50000);
		send_item(16'd54613, 17'd65537, 17'd30000);
		send_item(16'd5000, '1, 17'd60000);
		send_item(16'd20000, 17'd30000, 17'd65537);
		send_item(16'd40000, 17'd30000, '1);
		send_item('1, '1, '1);
		send_item(16'd30000, '0, 17'd45000);
		send_item(16'd60000, 17'd50000, '0);
		send_item(16'h5555, 17'h0aaaa, 17'h15555);
		send_item(16'haaaa, 17'h15555, 17'h0aaaa);
		drain();

		send_pct = 0;
		stall_pct <= 0;
		send_random(ITEMS_PER_PHASE);
		send_pct = 59;
		stall_pct <= 0;
		send_random(ITEMS_PER_PHASE);
		drain();
		send_pct = 0;
		stall_pct <= 59;
		send_random(ITEMS_PER_PHASE);
		send_pct = 32;
		stall_pct <= 32;
		send_random(ITEMS_PER_PHASE);
		drain();

		// back-pressure: output held while input keeps offering
		send_pct = 0;
		stall_pct <= 0;
		hold_req <= 1'b1;
		send_random(60);
		drain();

		repeat (8) @(posedge clk);
		$display("covered %0d items: corner colors, four gap/stall mixes, long hold-off",
			sb.noted);
		$display("%0d results checked, %0d field errors", sb.matched, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsvrgb_checker.sv
tb/tb_hsv_to_rgb_converter.sv
